// ----- hw/rtl/olid_pkg.sv -----
// ----------------------------------------------------------------------------
// olid_pkg
// shared types, sizes and codes of the ordered list engine
// ----------------------------------------------------------------------------
package olid_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int POS_W  = 16;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// request codes
	localparam logic [1:0] REQ_PUSH    = 2'd0;
	localparam logic [1:0] REQ_DEL_KEY = 2'd1;
	localparam logic [1:0] REQ_DEL_POS = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic signed [31:0] value;
		logic [15:0]       position;
	} req_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] list_count;
	} rsp_word_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;
		logic del_key;
		logic del_pos;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/ordered_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// ordered list of up to DEPTH signed words with push-front and two deletes
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one word per request: req_type, value, position
//   rsp channel returns one word per request: status and list_count
//   a request word is taken into a holding register, and once rsp is free
//   the row of cells executes it: every cell compares its word to the key,
//   the first-match flag ripples from head to tail, and each cell either
//   keeps its word, takes its head-side neighbor (push) or takes its
//   tail-side neighbor (delete closes the gap)
//   the result is registered in the response register, which drives
//   rsp_valid and rsp
//   throughput: one request per cycle while rsp is taken; the next request
//   is taken into the input register as the current one executes
//   rsp_stall holds the response register; a request waiting to execute
//   waits for that register, and req_stall goes high meanwhile
//   reset clears the count (empty list) and both valid flags; the cell
//   words need no reset, slots at or past the count are never read
// ----------------------------------------------------------------------------
module ordered_list_insert_delete
	import olid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	// request holding register
	logic      busy_q;
	req_word_t req_q;

	// list state
	logic [CNT_W-1:0] count_q;

	// response register
	logic      rsp_valid_q;
	rsp_word_t rsp_q;

	// cell row wiring
	word_t        words [DEPTH];
	logic [DEPTH:0] hit;
	cell_ctl_t    ctl;

	logic             complete;
	logic             full;
	logic             pos_found;
	logic             key_found;
	logic [1:0]       status_d;
	logic [CNT_W-1:0] count_d;

	// held request executes once the response register can take its result
	assign complete  = busy_q & (~rsp_valid_q | ~rsp_stall);
	assign req_stall = busy_q & ~complete;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign pos_found = ({{(32-POS_W){1'b0}}, req_q.position} < 32'(count_q));
	assign key_found = hit[DEPTH];

	// command broadcast to the row; push and position delete only on a change
	always_comb begin
		ctl.push    = complete & (req_q.req_type == REQ_PUSH) & ~full;
		ctl.del_key = complete & (req_q.req_type == REQ_DEL_KEY);
		ctl.del_pos = complete & (req_q.req_type == REQ_DEL_POS) & pos_found;
	end

	// status and new count of the executing request
	always_comb begin
		status_d = ST_DONE;
		count_d  = count_q;
		case (req_q.req_type)
			REQ_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			REQ_DEL_KEY: begin
				if (key_found) begin
					count_d = count_q - 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			REQ_DEL_POS: begin
				if (pos_found) begin
					count_d = count_q - 1'b1;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			default: begin
				// unused code: no change, done
				status_d = ST_DONE;
			end
		endcase
	end

	// the head of the match chain starts clear
	assign hit[0] = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			word_t prev_w;
			word_t next_w;
			logic  live;
			logic  past_pos;

			// head slot takes the pushed word, tail slot has no neighbor behind
			if (gi == 0) begin : g_head
				assign prev_w = req_q.value;
			end else begin : g_mid
				assign prev_w = words[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign next_w = words[gi];
			end else begin : g_body
				assign next_w = words[gi+1];
			end

			assign live     = (count_q > CNT_W'(gi));
			assign past_pos = (POS_W'(gi) >= req_q.position);

			olid_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.key       (req_q.value),
				.prev_word (prev_w),
				.next_word (next_w),
				.live      (live),
				.past_pos  (past_pos),
				.hit_in    (hit[gi]),
				.word      (words[gi]),
				.hit_out   (hit[gi+1])
			);
		end
	endgenerate

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid & ~req_stall) begin
				busy_q <= 1'b1;
			end else if (complete) begin
				busy_q <= 1'b0;
			end
			if (complete) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (~rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid & ~req_stall) begin
			req_q <= req;
		end
		if (complete) begin
			rsp_q.status     <= status_d;
			rsp_q.list_count <= 5'(count_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count never leaves the list bounds
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list count past depth");

	// push on a full list reports full and leaves the count alone
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(complete && req_q.req_type == REQ_PUSH && full) |=>
		(rsp_q.status == ST_FULL && count_q == $past(count_q)))
		else $error("full push changed the list");

	// a taken push grows the list by one
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(complete && req_q.req_type == REQ_PUSH && !full) |=>
		(count_q == $past(count_q) + 1'b1 && rsp_q.status == ST_DONE))
		else $error("push did not grow the list");

	// a response that waits is never overwritten by the executing request
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !complete)
		else $error("stalled response overwritten");

endmodule

// ----- hw/rtl/olid_cell.sv -----
// ----------------------------------------------------------------------------
// olid_cell
// one list slot: holds a word, compares it to the key, shifts with neighbors
// ----------------------------------------------------------------------------
module olid_cell
	import olid_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  word_t     key,
	input  word_t     prev_word,
	input  word_t     next_word,
	input  logic      live,
	input  logic      past_pos,
	input  logic      hit_in,
	output word_t     word,
	output logic      hit_out
);

	word_t word_q;

	// first match seen at this slot or closer to the head
	assign hit_out = hit_in | (live & ctl.del_key & (word_q == key));
	assign word    = word_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			word_q <= prev_word;
		end else if ((ctl.del_key & hit_out) | (ctl.del_pos & past_pos)) begin
			word_q <= next_word;
		end
	end

endmodule

// ----- tb/list_checker.sv -----
// ----------------------------------------------------------------------------
// list_checker
// watches both channels of the ordered list engine, keeps a shadow list,
// predicts the response of every accepted request word and compares it
// field by field with the responses that come back, in order
// ----------------------------------------------------------------------------
module list_checker
	import olid_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_stall,
	input  req_word_t req,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_word_t rsp,
	output int        mismatches,
	output int        pending
);

	word_t     shadow_words[$];
	rsp_word_t predicted_rsp[$];

	// apply one request to the shadow list, return the response it earns
	function automatic rsp_word_t list_apply(input req_word_t r);
		rsp_word_t o;
		int        hit;
		int        i;
		o.status = ST_DONE;
		hit = -1;
		case (r.req_type)
			REQ_PUSH: begin
				if (shadow_words.size() >= DEPTH)
					o.status = ST_FULL;
				else
					shadow_words.push_front(r.value);
			end
			REQ_DEL_KEY: begin
				for (i = 0; i < shadow_words.size() && hit < 0; i++)
					if (shadow_words[i] == r.value)
						hit = i;
				if (hit < 0)
					o.status = ST_NOT_FOUND;
				else
					shadow_words.delete(hit);
			end
			REQ_DEL_POS: begin
				if (int'(r.position) < shadow_words.size())
					shadow_words.delete(int'(r.position));
				else
					o.status = ST_NOT_FOUND;
			end
			default: ;
		endcase
		o.list_count = 5'(shadow_words.size());
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			shadow_words.delete();
			predicted_rsp.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			// retire first: a response can never belong to a word taken at this edge
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp.size() == 0) begin
					$display("%0t: unexpected response, expected none, got status %0d count %0d",
						$time, rsp.status, rsp.list_count);
					mismatches <= mismatches + 1;
				end else begin
					want = predicted_rsp.pop_front();
					if (rsp.status !== want.status || rsp.list_count !== want.list_count) begin
						$display("%0t: response expected status %0d count %0d, got status %0d count %0d",
							$time, want.status, want.list_count, rsp.status, rsp.list_count);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req_valid && !req_stall)
				predicted_rsp.push_back(list_apply(req));
			pending <= predicted_rsp.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the ordered list engine: a directed opening
// covering the word extremes, every request kind, a full list, missing keys
// and out-of-range positions, then random traffic in phases that bias
// toward filling, draining or churning the list, with random gaps and
// response stalls; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb;
	import olid_pkg::*;

	// request code the block treats as a no-op
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int SEGMENT_LEN  = 40;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	int mismatches;
	int pending;
	int cycles = 0;

	// tallies for the closing summary
	int n_push = 0;
	int n_del_key = 0;
	int n_del_pos = 0;
	int n_unused = 0;

	// sender behavior of the current random segment
	bit quiet_tx = 1'b0;
	int push_pct = 50;

	// recently pushed words, so key deletes hit often
	word_t recent_values[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ordered_list_insert_delete DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	list_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses still owed", cycles, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// response side: short stalls mostly, a few long ones, and now and then
	// a quiet stretch where every response is taken at once
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left == 0) begin
			if ($urandom_range(0, 99) < 6) begin
				rsp_stall  <= 1'b0;
				stall_left = $urandom_range(30, 80);
			end else if ($urandom_range(0, 99) < 60) begin
				rsp_stall  <= 1'b0;
				stall_left = $urandom_range(0, 5);
			end else begin
				rsp_stall  <= 1'b1;
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				                                          : $urandom_range(0, 2);
			end
		end else begin
			stall_left--;
		end
	end

	// present one word and hold it until taken; stall is sampled at the
	// falling edge, the word is taken at the rising edge after it
	task automatic send_word(input req_word_t w);
		req       <= w;
		req_valid <= 1'b1;
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	// sender gap after a word: mostly none or short, a few long
	task automatic sender_gap();
		int roll;
		int g;
		roll = $urandom_range(0, 99);
		if (quiet_tx || roll < 65)
			g = 0;
		else if (roll < 95)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(10, 40);
		if (g > 0) begin
			req_valid <= 1'b0;
			// junk on the payload while idle, the block must ignore it
			req <= '{req_type: 2'($urandom()), value: $urandom(), position: 16'($urandom())};
			repeat (g) @(posedge clk);
		end
	endtask

	// hold the sender off until every response has come back
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic issue(input logic [1:0] kind, input word_t v, input logic [15:0] p);
		send_word('{req_type: kind, value: v, position: p});
		case (kind)
			REQ_PUSH: begin
				n_push++;
				recent_values.push_back(v);
				if (recent_values.size() > DEPTH)
					void'(recent_values.pop_front());
			end
			REQ_DEL_KEY: n_del_key++;
			REQ_DEL_POS: n_del_pos++;
			default:     n_unused++;
		endcase
		sender_gap();
	endtask

	// word value: a recent push, a small signed alphabet, or a full random word
	function automatic word_t pick_value(input bit prefer_recent);
		int roll;
		roll = $urandom_range(0, 99);
		if (prefer_recent && roll < 40 && recent_values.size() > 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		else if (roll < 70)
			return word_t'(int'($urandom_range(0, 7)) - 4);
		else
			return word_t'($urandom());
	endfunction

	initial begin
		logic [1:0]  kind;
		logic [15:0] p;
		int          roll;
		int          useful;
		int          segment_left;
		bit          paused_mid;

		// reset held at the start, then released
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: operations on the empty list, then the no-op code
		issue(REQ_DEL_KEY, 32'sd0, 16'h0000);
		issue(REQ_DEL_POS, 32'sd7, 16'h0000);
		issue(REQ_UNUSED, word_t'($urandom()), 16'hffff);

		// fill to capacity with the word extremes and a duplicate key
		issue(REQ_PUSH, 32'sh8000_0000, 16'hffff);
		issue(REQ_PUSH, 32'sh7fff_ffff, 16'h0000);
		issue(REQ_PUSH, 32'sd0, 16'h1234);
		issue(REQ_PUSH, -32'sd1, 16'h0001);
		issue(REQ_PUSH, 32'sh5555_5555, 16'haaaa);
		issue(REQ_PUSH, 32'shaaaa_aaaa, 16'h5555);
		for (int i = 1; i <= 10; i++)
			issue(REQ_PUSH, word_t'(i == 9 ? 5 : i), 16'($urandom()));

		// push on a full list is dropped
		issue(REQ_PUSH, 32'sd99, 16'h0000);

		// key that sits twice: only the one nearer the head goes
		issue(REQ_DEL_KEY, 32'sd5, 16'hffff);
		// missing key
		issue(REQ_DEL_KEY, 32'sd12345, 16'h0000);
		// head, tail, just past the tail, farthest position
		issue(REQ_DEL_POS, 32'sh7fff_ffff, 16'd0);
		issue(REQ_DEL_POS, 32'sd0, 16'd13);
		issue(REQ_DEL_POS, 32'sd0, 16'd13);
		issue(REQ_DEL_POS, 32'sd0, 16'hffff);

		// let everything settle before the random part
		wait_drained();

		useful       = 0;
		segment_left = 0;
		paused_mid   = 1'b0;
		while (useful < RANDOM_ITEMS) begin
			// each segment either fills, drains or churns the list
			if (segment_left == 0) begin
				roll = $urandom_range(0, 2);
				push_pct = (roll == 0) ? 80 : (roll == 1) ? 50 : 20;
				quiet_tx = ($urandom_range(0, 3) == 0);
				segment_left = SEGMENT_LEN;
			end
			if (!paused_mid && useful >= RANDOM_ITEMS / 2) begin
				wait_drained();
				paused_mid = 1'b1;
			end

			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				kind = REQ_PUSH;
			else if (roll < 96)
				kind = roll[0] ? REQ_DEL_KEY : REQ_DEL_POS;
			else
				kind = REQ_UNUSED;
			// positions mostly near the list, sometimes anywhere
			p = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, DEPTH + 1))
			                                  : 16'($urandom());
			issue(kind, pick_value(kind == REQ_DEL_KEY), p);
			if (kind != REQ_UNUSED)
				useful++;
			segment_left--;
		end

		// every response back, then an idle stretch for stray words
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d pushes, %0d key deletes, %0d position deletes, %0d no-ops",
			n_push, n_del_key, n_del_pos, n_unused);
		$display("phases filled, drained and churned the list under random gaps and stalls");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/olid_pkg.sv
hw/rtl/olid_cell.sv
hw/rtl/ordered_list_insert_delete.sv
tb/list_checker.sv
tb/tb.sv
